>>> sv/iwq_pkg.sv
// Shared types, constants and address helpers for the int8 weight quantizer.
package iwq_pkg;

  localparam int unsigned MaxChannelsDefault = 4096;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned NumWidth = 40;
  localparam int unsigned RemWidth = 41;
  localparam int unsigned QuantSteps = 8;

  localparam logic [6:0] QuantMax = 7'd127;
  localparam logic [7:0] BoundScale = 8'd254;
  localparam logic [12:0] ChannelCountReset = 13'd32;

  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_LAYOUT_MODE   = 2'd1,
    REG_PER_CHANNEL   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    KIND_BOUND  = 1'b0,
    KIND_WEIGHT = 1'b1
  } item_kind_t;

  // One classified item on its way from the front end to the divider.
  typedef struct packed {
    logic [NumWidth-1:0] num;
    logic [31:0]         amax;
    logic                neg;
    logic                zero;
    logic [23:0]         addr;
  } queue_entry_t;

  // Two's complement magnitude; the most negative value maps to 2^31.
  function automatic logic [31:0] magnitude(input logic [31:0] w);
    return w[31] ? (~w + 32'd1) : w;
  endfunction

  // Byte offset inside a 32-column tile for both tile orders.
  function automatic logic [23:0] tile_offset(input logic [11:0] r, input logic [11:0] c,
                                              input logic mode);
    logic [23:0] off;
    if (mode) begin
      off = {7'd0, r[11:5], r[2:1], r[4:3], r[0], c[4:0]};
    end else begin
      off = {7'd0, r[11:3], r[0], c[4:3], c[2], r[2:1], c[1:0]};
    end
    return off;
  endfunction

endpackage

>>> sv/iwq_front.sv
// Front end: configuration, scale storage, classification and address generation.
module iwq_front import iwq_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MaxChannelsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               accept,
  input  logic               kind,
  input  logic [11:0]        channel_index,
  input  logic [11:0]        column_index,
  input  logic [31:0]        weight_value,
  input  logic [31:0]        bound_max,
  input  logic [31:0]        bound_min,
  output logic               push,
  output queue_entry_t       push_entry
);

  localparam int unsigned CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [12:0] channel_count;
  logic        layout_mode;
  logic        per_channel;
  logic [31:0] shared_scale;
  logic [31:0] scale_mem [MAX_CHANNELS];

  logic        s1_valid;
  logic        s1_kind;
  logic [11:0] s1_r;
  logic [11:0] s1_c;
  logic [31:0] s1_weight;
  logic [31:0] s1_bound_amax;
  logic        s1_in_range;
  logic [31:0] s1_mem_data;

  logic [31:0] mag_max;
  logic [31:0] mag_min;
  logic [31:0] bound_amax;
  logic        in_range;
  logic [CW-1:0] mem_index;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= ChannelCountReset;
      layout_mode <= 1'b0;
      per_channel <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_CHANNEL_COUNT: channel_count <= cfg_data;
        REG_LAYOUT_MODE:   layout_mode <= cfg_data[0];
        REG_PER_CHANNEL:   per_channel <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Bound magnitudes and table index of the incoming beat.
  always_comb begin
    mag_max = magnitude(bound_max);
    mag_min = magnitude(bound_min);
    bound_amax = (mag_max > mag_min) ? mag_max : mag_min;
    in_range = 32'(channel_index) < 32'(MAX_CHANNELS);
    mem_index = CW'(channel_index);
  end

  // Shared scale is loaded from the bound_max magnitude by a bound beat on channel 0 when per_channel is off.
  always_ff @(posedge clk) begin
    if (rst) begin
      shared_scale <= '0;
    end else if (accept && kind == KIND_BOUND && !per_channel && channel_index == '0) begin
      shared_scale <= mag_max;
    end
  end

  // Per-channel scale table with a registered read.
  always_ff @(posedge clk) begin
    if (accept && kind == KIND_BOUND && per_channel && in_range) begin
      scale_mem[mem_index] <= bound_amax;
    end
    s1_mem_data <= scale_mem[mem_index];
  end

  // Stage 1 holds the accepted beat while the table read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_kind <= kind;
    s1_r <= channel_index;
    s1_c <= column_index;
    s1_weight <= weight_value;
    s1_bound_amax <= bound_amax;
    s1_in_range <= in_range;
  end

  // Classify and build the queue entry.
  always_comb begin
    logic [31:0] amax;
    logic [31:0] wmag;
    logic [19:0] tile_base;
    logic [24:0] base_addr;
    if (s1_kind == KIND_BOUND) begin
      amax = per_channel ? s1_bound_amax : shared_scale;
    end else if (per_channel) begin
      amax = s1_in_range ? s1_mem_data : '0;
    end else begin
      amax = shared_scale;
    end
    wmag = (s1_kind == KIND_WEIGHT) ? magnitude(s1_weight) : '0;
    tile_base = 20'(s1_c[11:5]) * 20'(channel_count);
    base_addr = {tile_base, 5'd0};
    push = s1_valid;
    push_entry.num = NumWidth'(wmag) * NumWidth'(BoundScale) + NumWidth'(amax);
    push_entry.amax = amax;
    push_entry.neg = s1_weight[31];
    push_entry.zero = (wmag == '0);
    push_entry.addr = (s1_kind == KIND_WEIGHT)
                      ? (base_addr[23:0] + tile_offset(s1_r, s1_c, layout_mode)) : '0;
  end

endmodule

>>> sv/iwq_queue.sv
// Short queue between the front end and the divider.
module iwq_queue import iwq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  queue_entry_t push_entry,
  input  logic         pop,
  output logic         not_empty,
  output queue_entry_t head,
  output logic [2:0]   count
);

  queue_entry_t entries [QueueDepth];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;

  assign not_empty = count != '0;
  assign head = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_entry;
  end

endmodule

>>> sv/iwq_back.sv
// Back end: pipelined restoring divider, one quotient bit per stage, and output register.
module iwq_back import iwq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         not_empty,
  input  queue_entry_t head,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [63:0]  out_data
);

  logic                  en;
  logic                  v    [QuantSteps+1];
  logic [RemWidth-1:0]   rem  [QuantSteps+1];
  logic [31:0]           amax [QuantSteps+1];
  logic [QuantSteps-1:0] quot [QuantSteps+1];
  logic                  sat  [QuantSteps+1];
  logic                  neg  [QuantSteps+1];
  logic                  zero [QuantSteps+1];
  logic [23:0]           addr [QuantSteps+1];

  assign en = !v[QuantSteps] || out_ready;
  assign pop = en && not_empty;
  assign out_valid = v[QuantSteps];

  // Stage 0 loads the numerator and flags saturation at 256 or more.
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= not_empty;
    end
    if (en) begin
      rem[0] <= RemWidth'(head.num);
      amax[0] <= head.amax;
      quot[0] <= '0;
      sat[0] <= RemWidth'(head.num) >= {head.amax, 9'd0};
      neg[0] <= head.neg;
      zero[0] <= head.zero;
      addr[0] <= head.addr;
    end
  end

  // One restoring step per stage, quotient bit QuantSteps-j.
  for (genvar j = 1; j <= QuantSteps; j++) begin : g_step
    logic [RemWidth-1:0] dk;
    logic                take;
    assign dk = RemWidth'({amax[j-1], 1'b0}) << (QuantSteps - j);
    assign take = rem[j-1] >= dk;
    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en) begin
        v[j] <= v[j-1];
      end
      if (en) begin
        rem[j] <= take ? (rem[j-1] - dk) : rem[j-1];
        quot[j] <= quot[j-1] | (take ? (QuantSteps'(1) << (QuantSteps - j)) : '0);
        amax[j] <= amax[j-1];
        sat[j] <= sat[j-1];
        neg[j] <= neg[j-1];
        zero[j] <= zero[j-1];
        addr[j] <= addr[j-1];
      end
    end
  end

  // Clamp, sign and pack the result beat.
  always_comb begin
    logic [6:0] qmag;
    logic [7:0] qval;
    if (zero[QuantSteps]) begin
      qmag = '0;
    end else if (sat[QuantSteps] || quot[QuantSteps][QuantSteps-1]) begin
      qmag = QuantMax;
    end else begin
      qmag = quot[QuantSteps][6:0];
    end
    qval = neg[QuantSteps] ? (8'd0 - {1'b0, qmag}) : {1'b0, qmag};
    out_data = {amax[QuantSteps], addr[QuantSteps], qval};
  end

endmodule

>>> sv/int8_weight_quantize_tiled.sv
// Top level of the tiled symmetric int8 weight quantizer.
//
//  Channel  Direction  Payload
//  s_axis   in         tuser: kind; tdata: channel_index, column_index, weight_value,
//                      bound_max, bound_min
//  m_axis   out        tdata: quantized_value, dest_address, amax_out
//  cfg      in         cfg_index selects channel_count, layout_mode, per_channel
//
// One item per cycle unless stalled; path: table read, queue, nine divider stages.
// The divider pipeline produces one quotient bit per stage.
// Reset clears control state, the shared scale and the configuration; the per-channel
// scale table is not cleared.
// A stalled output holds the divider pipeline; input stalls once queue credits run out.
module int8_weight_quantize_tiled import iwq_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MaxChannelsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,  // channel_index, column_index, weight_value,
                                      // bound_max, bound_min
  input  logic         s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // quantized_value, dest_address, amax_out
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [12:0]  cfg_data
);

  logic         accept;
  logic         push;
  logic         pop;
  logic         not_empty;
  logic [2:0]   count;
  queue_entry_t push_entry;
  queue_entry_t head;
  logic         s1_busy;

  assign cfg_ready = 1'b1;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Credit check: items in the table-read stage also need a queue slot.
  always_ff @(posedge clk) begin
    if (rst) s1_busy <= 1'b0;
    else s1_busy <= accept;
  end
  assign s_axis_tready = (32'(count) + 32'(s1_busy)) < 32'(QueueDepth);

  iwq_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .accept(accept), .kind(s_axis_tuser),
    .channel_index(s_axis_tdata[11:0]), .column_index(s_axis_tdata[23:12]),
    .weight_value(s_axis_tdata[55:24]), .bound_max(s_axis_tdata[87:56]),
    .bound_min(s_axis_tdata[119:88]),
    .push(push), .push_entry(push_entry)
  );

  iwq_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_entry(push_entry), .pop(pop),
    .not_empty(not_empty), .head(head), .count(count)
  );

  iwq_back u_back (
    .clk(clk), .rst(rst), .not_empty(not_empty), .head(head), .pop(pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
  );

endmodule

>>> sv/iwq_checker.sv
// Port-level checks for the quantizer, bound to the top level.
module iwq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // No result appears right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // The quantized value never reaches -128.
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:0] != 8'h80)
    else $error("quantized value out of range");

  // The input ready is always a clean level while a beat is offered.
  a_in_ready_known: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid |-> !$isunknown(s_axis_tready))
    else $error("input ready unknown");

endmodule

bind int8_weight_quantize_tiled iwq_checker u_iwq_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

>>> tb/int8_weight_quantize_tiled_tb.sv
// Self-checking testbench for the tiled int8 weight quantizer.
`timescale 1ns / 1ps

module int8_weight_quantize_tiled_tb;
  import iwq_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int TableDepth = 4096;

  // One input beat before packing.
  typedef struct {
    item_kind_t  kind;
    logic [11:0] chan;
    logic [11:0] col;
    logic [31:0] weight;
    logic [31:0] bmax;
    logic [31:0] bmin;
  } quant_item_t;

  // One predicted output beat.
  typedef struct {
    logic [7:0]  qval;
    logic [23:0] addr;
    logic [31:0] amax;
  } quant_result_t;

  // Predicts quantized weights and addresses and checks the output stream.
  class quant_scoreboard;
    logic [31:0]   scale_tab[TableDepth];
    bit            written[TableDepth];
    logic [31:0]   shared_amax;
    logic [12:0]   chan_count;
    bit            tile_mode;
    bit            per_chan;
    quant_result_t pending_q[$];
    int            errors;

    function new();
      shared_amax = 0;
      chan_count = ChannelCountReset;
      tile_mode = 0;
      per_chan = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [12:0] val);
      case (idx)
        REG_CHANNEL_COUNT: chan_count = val;
        REG_LAYOUT_MODE:   tile_mode = val[0];
        REG_PER_CHANNEL:   per_chan = val[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] abs32(logic [31:0] w);
      return w[31] ? 32'd0 - w : w;
    endfunction

    // Byte offset within a 32-column tile, arithmetic form.
    function longint unsigned tile_pos(int unsigned r, int unsigned c);
      int unsigned a, b, t, s;
      if (!tile_mode) begin
        a = ((r >> 3) << 3) + ((r & 1) << 2) + ((c & 31) >> 3);
        b = (((c & 7) >= 4) ? 4 : 0) + ((r & 7) >> 1);
        return (a << 5) + (b << 2) + (c & 3);
      end
      t = r & 31;
      s = (((((t & 7) >> 1) << 2) + (t >> 3)) << 1) + (t & 1);
      return ((r >> 5) << 10) + (s << 5) + (c & 31);
    endfunction

    function void note_input(quant_item_t it);
      quant_result_t    res;
      logic [31:0]      mx, mn, amax;
      longint unsigned  mag, q;
      if (it.kind == KIND_BOUND) begin
        if (per_chan) begin
          mx = abs32(it.bmax);
          mn = abs32(it.bmin);
          amax = (mx > mn) ? mx : mn;
          scale_tab[it.chan] = amax;
          written[it.chan] = 1;
        end else begin
          if (it.chan == 0) shared_amax = abs32(it.bmax);
          amax = shared_amax;
        end
        res.qval = 0;
        res.addr = 0;
        res.amax = amax;
      end else begin
        amax = per_chan ? scale_tab[it.chan] : shared_amax;
        mag = 64'(abs32(it.weight));
        if (mag == 0) q = 0;
        else if (amax == 0) q = 127;
        else begin
          q = (mag * 254 + amax) / (longint'(amax) * 2);
          if (q > 127) q = 127;
        end
        res.qval = it.weight[31] ? 8'(-q) : 8'(q);
        res.addr = 24'(longint'(it.col >> 5) * 32 * chan_count + tile_pos(it.chan, it.col));
        res.amax = amax;
      end
      pending_q.push_back(res);
    endfunction

    function void check_result(logic [63:0] d);
      quant_result_t exp_r;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output beat %h", d);
        return;
      end
      exp_r = pending_q.pop_front();
      if (d[7:0] !== exp_r.qval || d[31:8] !== exp_r.addr || d[63:32] !== exp_r.amax) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: q exp %0d got %0d, addr exp %h got %h, amax exp %h got %h",
                   $signed(exp_r.qval), $signed(d[7:0]), exp_r.addr, d[31:8],
                   exp_r.amax, d[63:32]);
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;  // channel_index, column_index, weight_value, bound_max, bound_min
  logic         s_axis_tuser = 0;   // kind
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [63:0]  m_axis_tdata;       // quantized_value, dest_address, amax_out
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [12:0]  cfg_data = '0;

  quant_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int stall_pct = 0;

  int8_weight_quantize_tiled dut (.*);

  always #5 clk = ~clk;

  // Receiver stalls at a random rate that is redrawn periodically and is sometimes zero.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (cycles % 300 == 0) stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    if (cycles > CycleLimit) begin
      $display("int8_weight_quantize_tiled test failed");
      $finish;
    end
  end

  task automatic write_cfg(cfg_reg_t idx, logic [12:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Drive one beat; bursts of random length are separated by random gaps.
  task automatic send_item(quant_item_t it);
    if (burst_left == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tuser <= it.kind;
    s_axis_tdata <= {it.bmin, it.bmax, it.weight, it.col, it.chan};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(it);
  endtask

  // Stop sending and wait for every predicted beat, then idle before returning.
  task automatic drain();
    s_axis_tvalid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_fields(item_kind_t k, int unsigned ch, int unsigned col,
                             logic [31:0] w, logic [31:0] bmx, logic [31:0] bmn);
    quant_item_t it;
    it.kind = k;
    it.chan = 12'(ch);
    it.col = 12'(col);
    it.weight = w;
    it.bmax = bmx;
    it.bmin = bmn;
    send_item(it);
  endtask

  // Random signed value with a random magnitude range.
  function automatic logic [31:0] rand_q16();
    logic [31:0] v;
    v = $urandom() >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? 32'd0 - v : v;
  endfunction

  task automatic random_items(int count);
    quant_item_t it;
    int          picks[$];
    int          ch;
    for (int i = 0; i < count; i++) begin
      it.col = 12'($urandom());
      it.weight = rand_q16();
      it.bmax = rand_q16();
      it.bmin = rand_q16();
      it.chan = 12'($urandom());
      it.kind = ($urandom_range(0, 99) < 30) ? KIND_BOUND : KIND_WEIGHT;
      if (!sb.per_chan && it.kind == KIND_BOUND && $urandom_range(0, 2) != 0) it.chan = 0;
      if (sb.per_chan && it.kind == KIND_WEIGHT) begin
        // Only channels with a loaded scale may be read back.
        picks = '{};
        repeat (8) begin
          ch = $urandom_range(0, TableDepth - 1);
          if (sb.written[ch]) picks.push_back(ch);
        end
        if (picks.size() == 0) it.kind = KIND_BOUND;
        else it.chan = 12'(picks[0]);
      end
      // Weights close to the scale exercise rounding and clamping.
      if (it.kind == KIND_WEIGHT && $urandom_range(0, 2) == 0)
        it.weight = sb.per_chan ? sb.scale_tab[it.chan] >> $urandom_range(0, 8)
                                : sb.shared_amax >> $urandom_range(0, 8);
      send_item(it);
      if (i == count / 2 && $urandom_range(0, 1)) drain();
    end
  endtask

  task automatic set_phase(logic [12:0] n, bit mode, bit pc);
    drain();
    write_cfg(REG_CHANNEL_COUNT, n);
    write_cfg(REG_LAYOUT_MODE, 13'(mode));
    write_cfg(REG_PER_CHANNEL, 13'(pc));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Shared scale, starting from a zero scale.
    send_fields(KIND_WEIGHT, 3, 17, 32'd5, 0, 0);
    send_fields(KIND_WEIGHT, 3, 17, -32'sd5, 0, 0);
    send_fields(KIND_WEIGHT, 0, 0, 32'd0, 0, 0);
    send_fields(KIND_BOUND, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff);
    send_fields(KIND_WEIGHT, 4095, 4095, 32'h7fff_ffff, 0, 0);
    send_fields(KIND_WEIGHT, 4095, 4095, 32'h8000_0000, 0, 0);
    send_fields(KIND_BOUND, 5, 9, 0, 32'd77, 32'd1);
    send_fields(KIND_BOUND, 0, 0, 0, 32'd254, 32'hffff_ffff);
    send_fields(KIND_WEIGHT, 9, 40, 32'd1, 0, 0);
    send_fields(KIND_WEIGHT, 10, 41, 32'hffff_ffff, 0, 0);
    send_fields(KIND_WEIGHT, 11, 4, 32'd2, 0, 0);
    send_fields(KIND_WEIGHT, 12, 7, 32'd300, 0, 0);
    random_items(180);

    // Per-channel scales, including a zero scale and the top channel.
    set_phase(13'd4096, 1, 1);
    send_fields(KIND_BOUND, 4095, 0, 0, 32'd10, 32'h8000_0000);
    send_fields(KIND_BOUND, 7, 0, 0, 32'd0, 32'd0);
    send_fields(KIND_BOUND, 1, 0, 0, 32'd254, -32'sd10);
    send_fields(KIND_WEIGHT, 4095, 4095, 32'h8000_0000, 0, 0);
    send_fields(KIND_WEIGHT, 7, 33, 32'd9, 0, 0);
    send_fields(KIND_WEIGHT, 7, 34, -32'sd9, 0, 0);
    send_fields(KIND_WEIGHT, 7, 35, 32'd0, 0, 0);
    send_fields(KIND_WEIGHT, 1, 63, 32'd1, 0, 0);
    random_items(190);

    set_phase(13'd8191, 0, 1);
    random_items(190);
    set_phase(13'd33, 1, 0);
    random_items(190);
    set_phase(13'd32, 1, 1);
    random_items(190);
    set_phase(13'd4096, 0, 0);
    random_items(190);

    drain();
    if (sb.errors == 0) begin
      $display("int8_weight_quantize_tiled test passed");
    end else begin
      $display("int8_weight_quantize_tiled test failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/iwq_pkg.sv
sv/iwq_front.sv
sv/iwq_queue.sv
sv/iwq_back.sv
sv/int8_weight_quantize_tiled.sv
sv/iwq_checker.sv
tb/int8_weight_quantize_tiled_tb.sv
